/* design/wbm_pkg.sv */
// Shared constants for the weighted bipartite matcher.
package wbm_pkg;

    localparam int MAX_VERTICES_DEF = 64;
    localparam int WEIGHT_BITS_DEF  = 32;
    localparam int IDX_W            = 6;
    localparam int CFG_W            = 7;
    localparam logic [CFG_W-1:0] VCOUNT_RESET = 7'd64;

endpackage

/* design/wbm_ifs.sv */
// Request and result channel interfaces for the weighted bipartite matcher.
interface wbm_req_if #(
    parameter int WEIGHT_BITS = wbm_pkg::WEIGHT_BITS_DEF
) ();
    import wbm_pkg::*;

    logic                          valid;
    logic                          ready;
    logic [IDX_W-1:0]              row_index;
    logic [IDX_W-1:0]              col_index;
    logic signed [WEIGHT_BITS-1:0] edge_weight;
    logic                          last_entry;

    modport source (output valid, row_index, col_index, edge_weight, last_entry,
                    input ready);
    modport sink   (input valid, row_index, col_index, edge_weight, last_entry,
                    output ready);
endinterface

interface wbm_rsp_if ();
    import wbm_pkg::*;

    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] left_vertex;
    logic [IDX_W-1:0] right_vertex;
    logic             last_result;

    modport source (output valid, left_vertex, right_vertex, last_result, input ready);
    modport sink   (input valid, left_vertex, right_vertex, last_result, output ready);
endinterface

/* design/weighted_bipartite_matcher.sv */
// Top level: Kuhn-Munkres maximum-weight assignment over stored weight matrix.
//
//  channel  dir  handshake      payload
//  req      in   valid/ready    row_index, col_index, edge_weight, last_entry
//  rsp      out  valid/ready    left_vertex, right_vertex, last_result
//  cfg      in   cfg_we         cfg_wdata = vertex_count
//
// A request without last_entry only stores its weight. A last request also stores its
// weight and starts the solve: label init, then each examined edge costs weight, label
// and slack memory reads, then a compare, and each label update is a slack sweep and a
// label sweep; the worst case is bound by the single read port of each state memory.
// Results: n, each held until rsp.ready. No clearing pass after reset.
// req.ready is high only while idle.
module weighted_bipartite_matcher #(
    parameter int MAX_VERTICES = wbm_pkg::MAX_VERTICES_DEF,
    parameter int WEIGHT_BITS  = wbm_pkg::WEIGHT_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    wbm_req_if.sink                   req,
    wbm_rsp_if.source                 rsp,
    input  logic                      cfg_we,
    input  logic [wbm_pkg::CFG_W-1:0] cfg_wdata
);
    import wbm_pkg::*;

    localparam int AW   = $clog2(MAX_VERTICES);
    localparam int CW   = AW + 1;
    localparam int LW   = WEIGHT_BITS + 8;
    localparam int SW   = LW + 1;
    localparam int NAW  = 2 * AW;
    localparam int STKW = AW + CW;

    typedef enum logic [15:0] {
        S_IDLE  = 16'b0000_0000_0000_0001,
        S_INIT  = 16'b0000_0000_0000_0010,
        S_START = 16'b0000_0000_0000_0100,
        S_STEP  = 16'b0000_0000_0000_1000,
        S_POPW  = 16'b0000_0000_0001_0000,
        S_EVAL  = 16'b0000_0000_0010_0000,
        S_EVAL2 = 16'b0000_0000_0100_0000,
        S_UNW   = 16'b0000_0000_1000_0000,
        S_UNWW  = 16'b0000_0001_0000_0000,
        S_NXT   = 16'b0000_0010_0000_0000,
        S_DELTA = 16'b0000_0100_0000_0000,
        S_UPD   = 16'b0000_1000_0000_0000,
        S_INV   = 16'b0001_0000_0000_0000,
        S_ORD   = 16'b0010_0000_0000_0000,
        S_OLD   = 16'b0100_0000_0000_0000,
        S_OUT   = 16'b1000_0000_0000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [CFG_W-1:0]        vcount_reg;
    logic [CW-1:0]           n_eff;
    logic [CW-1:0]           n_reg, n_next;
    logic [CW-1:0]           nm1;
    logic [CW-1:0]           i_reg, i_next;
    logic [CW-1:0]           sw_reg, sw_next;
    logic                    pv_reg, pv_next;
    logic [AW-1:0]           pj_reg, pj_next;
    logic [CW-1:0]           sp_reg, sp_next;
    logic [AW-1:0]           cx_reg, cx_next;
    logic [CW-1:0]           cy_reg, cy_next;
    logic [MAX_VERTICES-1:0] lvis_reg, lvis_next;
    logic [MAX_VERTICES-1:0] rvis_reg, rvis_next;
    logic [MAX_VERTICES-1:0] sset_reg, sset_next;
    logic signed [WEIGHT_BITS-1:0] max_reg, max_next;
    logic signed [SW-1:0]    d_reg, d_next;
    logic [CW-1:0]           p_reg, p_next;
    logic signed [SW-1:0]    sk_reg, sk_next;
    logic                    skv_reg, skv_next;
    logic signed [SW-1:0]    delta_reg, delta_next;
    logic                    dok_reg, dok_next;
    logic [CW-1:0]           k_reg, k_next;
    logic                    ov_reg, ov_next;
    logic [IDX_W-1:0]        olv_reg, olv_next;
    logic [IDX_W-1:0]        orv_reg, orv_next;
    logic                    olast_reg, olast_next;

    logic                    sw_issue;
    logic                    sweep_done;
    logic                    pj_last;
    logic [CW-1:0]           sp_m1;
    logic [CW-1:0]           sp_m2;
    logic signed [WEIGHT_BITS-1:0] row_max;
    logic                    req_fire;

    // memories
    logic signed [WEIGHT_BITS-1:0] wmem [0:(1<<NAW)-1];
    logic                    w_we;
    logic [NAW-1:0]          w_waddr, w_raddr;
    logic signed [WEIGHT_BITS-1:0] w_wdata, w_rd;

    logic signed [LW-1:0]    llab [0:(1<<AW)-1];
    logic                    ll_we;
    logic [AW-1:0]           ll_waddr, ll_raddr;
    logic signed [LW-1:0]    ll_wdata, ll_rd;

    logic signed [LW-1:0]    rlab [0:(1<<AW)-1];
    logic                    rl_we;
    logic [AW-1:0]           rl_waddr, rl_raddr;
    logic signed [LW-1:0]    rl_wdata, rl_rd;

    logic signed [SW-1:0]    slk [0:(1<<AW)-1];
    logic                    sk_we;
    logic [AW-1:0]           sk_waddr, sk_raddr;
    logic signed [SW-1:0]    sk_wdata, sk_rd;

    logic [CW-1:0]           prt [0:(1<<AW)-1];
    logic                    pr_we;
    logic [AW-1:0]           pr_waddr, pr_raddr;
    logic [CW-1:0]           pr_wdata, pr_rd;

    logic [STKW-1:0]         stk [0:(1<<AW)-1];
    logic                    st_we;
    logic [AW-1:0]           st_waddr, st_raddr;
    logic [STKW-1:0]         st_wdata, st_rd;

    logic [AW-1:0]           rol [0:(1<<AW)-1];
    logic                    ro_we;
    logic [AW-1:0]           ro_waddr, ro_raddr;
    logic [AW-1:0]           ro_wdata, ro_rd;

    always_ff @(posedge clk)
    begin
        if (w_we)
        begin
            wmem[w_waddr] <= w_wdata;
        end
        w_rd <= wmem[w_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (ll_we)
        begin
            llab[ll_waddr] <= ll_wdata;
        end
        ll_rd <= llab[ll_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (rl_we)
        begin
            rlab[rl_waddr] <= rl_wdata;
        end
        rl_rd <= rlab[rl_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (sk_we)
        begin
            slk[sk_waddr] <= sk_wdata;
        end
        sk_rd <= slk[sk_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (pr_we)
        begin
            prt[pr_waddr] <= pr_wdata;
        end
        pr_rd <= prt[pr_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            stk[st_waddr] <= st_wdata;
        end
        st_rd <= stk[st_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (ro_we)
        begin
            rol[ro_waddr] <= ro_wdata;
        end
        ro_rd <= rol[ro_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg <= VCOUNT_RESET;
        end
        else if (cfg_we)
        begin
            vcount_reg <= cfg_wdata;
        end
    end

    always_comb
    begin
        if (vcount_reg == '0)
        begin
            n_eff = CW'(1);
        end
        else if (vcount_reg > CFG_W'(MAX_VERTICES))
        begin
            n_eff = CW'(MAX_VERTICES);
        end
        else
        begin
            n_eff = vcount_reg[CW-1:0];
        end
    end

    assign nm1        = n_reg - CW'(1);
    assign sw_issue   = (sw_reg < n_reg);
    assign sweep_done = !sw_issue && !pv_reg;
    assign pj_last    = ({1'b0, pj_reg} == nm1);
    assign sp_m1      = sp_reg - CW'(1);
    assign sp_m2      = sp_reg - CW'(2);
    assign req_fire   = req.valid && req.ready;
    assign row_max    = (pj_reg == '0 || w_rd > max_reg) ? w_rd : max_reg;

    assign req.ready        = (state_reg == S_IDLE);
    assign rsp.valid        = ov_reg;
    assign rsp.left_vertex  = olv_reg;
    assign rsp.right_vertex = orv_reg;
    assign rsp.last_result  = olast_reg;

    // read address selection
    assign w_raddr  = (state_reg == S_INIT) ? {i_reg[AW-1:0], sw_reg[AW-1:0]}
                                            : {cx_reg, cy_reg[AW-1:0]};
    assign ll_raddr = (state_reg == S_UPD) ? sw_reg[AW-1:0] : cx_reg;
    assign rl_raddr = (state_reg == S_UPD) ? sw_reg[AW-1:0] : cy_reg[AW-1:0];
    assign sk_raddr = (state_reg == S_DELTA) ? sw_reg[AW-1:0] : cy_reg[AW-1:0];
    assign pr_raddr = (state_reg == S_INV) ? sw_reg[AW-1:0] : cy_reg[AW-1:0];
    assign st_raddr = (state_reg == S_UNW) ? sp_m1[AW-1:0] : sp_m2[AW-1:0];
    assign ro_raddr = k_reg[AW-1:0];

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        i_next     = i_reg;
        sw_next    = sw_reg;
        pv_next    = pv_reg;
        pj_next    = pj_reg;
        sp_next    = sp_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        lvis_next  = lvis_reg;
        rvis_next  = rvis_reg;
        sset_next  = sset_reg;
        max_next   = max_reg;
        d_next     = d_reg;
        p_next     = p_reg;
        sk_next    = sk_reg;
        skv_next   = skv_reg;
        delta_next = delta_reg;
        dok_next   = dok_reg;
        k_next     = k_reg;
        ov_next    = ov_reg;
        olv_next   = olv_reg;
        orv_next   = orv_reg;
        olast_next = olast_reg;

        w_we     = 1'b0;
        w_waddr  = {req.row_index[AW-1:0], req.col_index[AW-1:0]};
        w_wdata  = req.edge_weight;
        ll_we    = 1'b0;
        ll_waddr = pj_reg;
        ll_wdata = ll_rd - LW'(delta_reg);
        rl_we    = 1'b0;
        rl_waddr = pj_reg;
        rl_wdata = rl_rd + LW'(delta_reg);
        sk_we    = 1'b0;
        sk_waddr = cy_reg[AW-1:0];
        sk_wdata = d_reg;
        pr_we    = 1'b0;
        pr_waddr = cy_reg[AW-1:0];
        pr_wdata = {1'b0, cx_reg};
        st_we    = 1'b0;
        st_waddr = sp_m1[AW-1:0];
        st_wdata = {cx_reg, cy_reg};
        ro_we    = 1'b0;
        ro_waddr = pr_rd[AW-1:0];
        ro_wdata = pj_reg;

        // shared sweep pipeline: issue index sw, data for pj arrives in the next cycle
        if (state_reg == S_INIT || state_reg == S_DELTA
            || state_reg == S_UPD || state_reg == S_INV)
        begin
            pv_next = sw_issue;
            pj_next = sw_reg[AW-1:0];
            if (sw_issue)
            begin
                sw_next = sw_reg + CW'(1);
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    w_we = ({1'b0, req.row_index} < CFG_W'(MAX_VERTICES))
                           && ({1'b0, req.col_index} < CFG_W'(MAX_VERTICES));
                    if (req.last_entry)
                    begin
                        n_next     = n_eff;
                        i_next     = '0;
                        sw_next    = '0;
                        pv_next    = 1'b0;
                        state_next = S_INIT;
                    end
                end
            end
            S_INIT:
            begin
                if (pv_reg)
                begin
                    max_next = row_max;
                    if (pj_last)
                    begin
                        ll_we    = 1'b1;
                        ll_waddr = i_reg[AW-1:0];
                        ll_wdata = LW'(row_max);
                        rl_we    = 1'b1;
                        rl_waddr = i_reg[AW-1:0];
                        rl_wdata = '0;
                        pr_we    = 1'b1;
                        pr_waddr = i_reg[AW-1:0];
                        pr_wdata = '1;
                    end
                end
                if (sweep_done)
                begin
                    sw_next = '0;
                    if (i_reg == nm1)
                    begin
                        i_next     = '0;
                        state_next = S_START;
                    end
                    else
                    begin
                        i_next = i_reg + CW'(1);
                    end
                end
            end
            S_START:
            begin
                lvis_next = '0;
                lvis_next[i_reg[AW-1:0]] = 1'b1;
                rvis_next  = '0;
                sset_next  = '0;
                cx_next    = i_reg[AW-1:0];
                cy_next    = '0;
                sp_next    = CW'(1);
                state_next = S_STEP;
            end
            S_STEP:
            begin
                if (cy_reg >= n_reg)
                begin
                    if (sp_reg == CW'(1))
                    begin
                        sw_next    = '0;
                        pv_next    = 1'b0;
                        dok_next   = 1'b0;
                        state_next = S_DELTA;
                    end
                    else
                    begin
                        state_next = S_POPW;
                    end
                end
                else if (rvis_reg[cy_reg[AW-1:0]])
                begin
                    cy_next = cy_reg + CW'(1);
                end
                else
                begin
                    state_next = S_EVAL;
                end
            end
            S_POPW:
            begin
                cx_next    = st_rd[STKW-1:CW];
                cy_next    = st_rd[CW-1:0] + CW'(1);
                sp_next    = sp_m1;
                state_next = S_STEP;
            end
            S_EVAL:
            begin
                d_next     = SW'(ll_rd) + SW'(rl_rd) - SW'(w_rd);
                p_next     = pr_rd;
                sk_next    = sk_rd;
                skv_next   = sset_reg[cy_reg[AW-1:0]];
                state_next = S_EVAL2;
            end
            S_EVAL2:
            begin
                state_next = S_STEP;
                if (d_reg == '0)
                begin
                    rvis_next[cy_reg[AW-1:0]] = 1'b1;
                    if (p_reg >= n_reg)
                    begin
                        // free right vertex: flip the path, top entry first
                        pr_we   = 1'b1;
                        sp_next = sp_m1;
                        state_next = (sp_reg == CW'(1)) ? S_NXT : S_UNW;
                    end
                    else if (sp_reg >= CW'(MAX_VERTICES))
                    begin
                        cy_next = cy_reg + CW'(1);
                    end
                    else
                    begin
                        lvis_next[p_reg[AW-1:0]] = 1'b1;
                        st_we   = 1'b1;
                        cx_next = p_reg[AW-1:0];
                        cy_next = '0;
                        sp_next = sp_reg + CW'(1);
                    end
                end
                else
                begin
                    if (!skv_reg || d_reg < sk_reg)
                    begin
                        sk_we = 1'b1;
                        sset_next[cy_reg[AW-1:0]] = 1'b1;
                    end
                    cy_next = cy_reg + CW'(1);
                end
            end
            S_UNW:
            begin
                state_next = S_UNWW;
            end
            S_UNWW:
            begin
                pr_we    = 1'b1;
                pr_waddr = st_rd[AW-1:0];
                pr_wdata = {1'b0, st_rd[STKW-1:CW]};
                sp_next  = sp_m1;
                state_next = (sp_reg == CW'(1)) ? S_NXT : S_UNW;
            end
            S_NXT:
            begin
                if (i_reg == nm1)
                begin
                    sw_next    = '0;
                    pv_next    = 1'b0;
                    state_next = S_INV;
                end
                else
                begin
                    i_next     = i_reg + CW'(1);
                    state_next = S_START;
                end
            end
            S_DELTA:
            begin
                if (pv_reg && !rvis_reg[pj_reg] && sset_reg[pj_reg]
                    && (!dok_reg || sk_rd < delta_reg))
                begin
                    delta_next = sk_rd;
                    dok_next   = 1'b1;
                end
                if (sweep_done)
                begin
                    sw_next    = '0;
                    state_next = dok_reg ? S_UPD : S_NXT;
                end
            end
            S_UPD:
            begin
                if (pv_reg)
                begin
                    ll_we = lvis_reg[pj_reg];
                    rl_we = rvis_reg[pj_reg];
                end
                if (sweep_done)
                begin
                    state_next = S_START;
                end
            end
            S_INV:
            begin
                if (pv_reg && pr_rd < n_reg)
                begin
                    ro_we = 1'b1;
                end
                if (sweep_done)
                begin
                    k_next     = '0;
                    state_next = S_ORD;
                end
            end
            S_ORD:
            begin
                state_next = S_OLD;
            end
            S_OLD:
            begin
                ov_next    = 1'b1;
                olv_next   = IDX_W'(k_reg);
                orv_next   = IDX_W'(ro_rd);
                olast_next = (k_reg == nm1);
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (rsp.ready)
                begin
                    ov_next = 1'b0;
                    if (olast_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + CW'(1);
                        state_next = S_ORD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            n_reg     <= CW'(1);
            i_reg     <= '0;
            sw_reg    <= '0;
            pv_reg    <= 1'b0;
            sp_reg    <= '0;
            cx_reg    <= '0;
            cy_reg    <= '0;
            lvis_reg  <= '0;
            rvis_reg  <= '0;
            sset_reg  <= '0;
            dok_reg   <= 1'b0;
            k_reg     <= '0;
            ov_reg    <= 1'b0;
            olast_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
            i_reg     <= i_next;
            sw_reg    <= sw_next;
            pv_reg    <= pv_next;
            sp_reg    <= sp_next;
            cx_reg    <= cx_next;
            cy_reg    <= cy_next;
            lvis_reg  <= lvis_next;
            rvis_reg  <= rvis_next;
            sset_reg  <= sset_next;
            dok_reg   <= dok_next;
            k_reg     <= k_next;
            ov_reg    <= ov_next;
            olast_reg <= olast_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pj_reg    <= pj_next;
        max_reg   <= max_next;
        d_reg     <= d_next;
        p_reg     <= p_next;
        sk_reg    <= sk_next;
        skv_reg   <= skv_next;
        delta_reg <= delta_next;
        olv_reg   <= olv_next;
        orv_reg   <= orv_next;
    end

    a_top_visited: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_STEP |-> lvis_reg[cx_reg])
        else $error("search top left vertex not marked visited");

    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= CW'(MAX_VERTICES))
        else $error("search stack overflow");

    a_rsp_state: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> state_reg == S_OUT)
        else $error("result valid outside output phase");

    a_solve_start: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && req.last_entry) |=> state_reg == S_INIT)
        else $error("last request did not start the solve");

    a_delta_found: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPD && pv_reg) |-> dok_reg)
        else $error("label update without a slack minimum");

endmodule
